FILE: hw/rtl/tpsa_pkg.sv
`timescale 1ns / 1ps

package tpsa_pkg;

  localparam int NUM_DIMS   = 4;
  localparam int MAX_DIMS   = 4;
  localparam int EXTENT_MAX = 1024;
  localparam int DIM_W      = 3;
  localparam int IDX_W      = 2;
  localparam int DIGIT_W    = 10;
  localparam int EXT_W      = 11;
  localparam int ADDR_W     = 40;
  localparam int VALUE_W    = 32;
  localparam int SCALE_W    = 24;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = VALUE_W + SCALE_W;
  localparam int MAG_W      = PROD_W + 1 - FRAC_W;
  localparam int PADDR_W    = 5;
  localparam int PDATA_W    = 32;

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [EXT_W-1:0]   ext_t;
  typedef logic [IDX_W-1:0]   dim_idx_t;

  typedef enum logic [DIM_W-1:0] {
    REG_DIM_COUNT  = 3'd0,
    REG_EXTENT_0   = 3'd1,
    REG_EXTENT_1   = 3'd2,
    REG_EXTENT_2   = 3'd3,
    REG_EXTENT_3   = 3'd4,
    REG_ORDER_MAP  = 3'd5,
    REG_SCALE      = 3'd6,
    REG_ACCUMULATE = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [DIM_W-1:0]             dim_count;
    ext_t [NUM_DIMS-1:0]          extent;
    logic [2*NUM_DIMS-1:0]        order_map;
    logic signed [SCALE_W-1:0]    scale_factor;
    logic                         accumulate_mode;
  } cfg_t;

  typedef struct packed {
    logic [VALUE_W-1:0]           vmag;
    logic                         vneg;
    digit_t [NUM_DIMS-1:0]        digits;
    dim_idx_t [NUM_DIMS-1:0]      perm;
    logic [DIM_W-1:0]             steps;
    logic                         last;
    logic                         bad;
    logic                         accum;
  } entry_t;

  function automatic ext_t eff_extent(input ext_t e);
    ext_t r;
    r = e;
    if (e == '0) r = EXT_W'(1);
    if (e > EXT_W'(EXTENT_MAX)) r = EXT_W'(EXTENT_MAX);
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] active_dims(input logic [DIM_W-1:0] d);
    logic [DIM_W-1:0] r;
    r = d;
    if (d > DIM_W'(NUM_DIMS)) r = DIM_W'(NUM_DIMS);
    if (r > DIM_W'(MAX_DIMS)) r = DIM_W'(MAX_DIMS);
    return r;
  endfunction

endpackage

FILE: hw/rtl/tpsa_in_if.sv
`timescale 1ns / 1ps

interface tpsa_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] source_value;

  modport source (output valid, output source_value, input ready);
  modport sink (input valid, input source_value, output ready);
endinterface

FILE: hw/rtl/tpsa_out_if.sv
`timescale 1ns / 1ps

interface tpsa_out_if;
  logic               valid;
  logic               ready;
  logic [39:0]        dest_address;
  logic signed [31:0] scaled_value;
  logic               add_to_existing;
  logic               last_element;
  logic               bad_order;

  modport source (output valid, output dest_address, output scaled_value,
                  output add_to_existing, output last_element, output bad_order,
                  input ready);
  modport sink (input valid, input dest_address, input scaled_value,
                input add_to_existing, input last_element, input bad_order,
                output ready);
endinterface

FILE: hw/rtl/tpsa_regs.sv
`timescale 1ns / 1ps

module tpsa_regs (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tpsa_pkg::PADDR_W-1:0]    paddr,
  input  logic [tpsa_pkg::PDATA_W-1:0]    pwdata,
  output logic [tpsa_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready,
  output tpsa_pkg::cfg_t                  cfg
);
  import tpsa_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dim_count       <= '0;
      cfg.extent          <= {NUM_DIMS{EXT_W'(1)}};
      cfg.order_map       <= 8'd228;
      cfg.scale_factor    <= 24'sd65536;
      cfg.accumulate_mode <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_DIM_COUNT:  cfg.dim_count       <= pwdata[DIM_W-1:0];
        REG_EXTENT_0:   cfg.extent[0]       <= pwdata[EXT_W-1:0];
        REG_EXTENT_1:   cfg.extent[1]       <= pwdata[EXT_W-1:0];
        REG_EXTENT_2:   cfg.extent[2]       <= pwdata[EXT_W-1:0];
        REG_EXTENT_3:   cfg.extent[3]       <= pwdata[EXT_W-1:0];
        REG_ORDER_MAP:  cfg.order_map       <= pwdata[2*NUM_DIMS-1:0];
        REG_SCALE:      cfg.scale_factor    <= pwdata[SCALE_W-1:0];
        REG_ACCUMULATE: cfg.accumulate_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DIM_COUNT:  prdata = PDATA_W'(cfg.dim_count);
      REG_EXTENT_0:   prdata = PDATA_W'(cfg.extent[0]);
      REG_EXTENT_1:   prdata = PDATA_W'(cfg.extent[1]);
      REG_EXTENT_2:   prdata = PDATA_W'(cfg.extent[2]);
      REG_EXTENT_3:   prdata = PDATA_W'(cfg.extent[3]);
      REG_ORDER_MAP:  prdata = PDATA_W'(cfg.order_map);
      REG_SCALE:      prdata = PDATA_W'(unsigned'(cfg.scale_factor));
      REG_ACCUMULATE: prdata = PDATA_W'(cfg.accumulate_mode);
      default:        prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/tpsa_front.sv
`timescale 1ns / 1ps

module tpsa_front (
  input  logic             clk,
  input  logic             rst,
  input  tpsa_pkg::cfg_t   cfg,
  tpsa_in_if.sink          src,
  input  logic             q_full,
  output logic             push,
  output tpsa_pkg::entry_t push_entry
);
  import tpsa_pkg::*;

  digit_t [NUM_DIMS-1:0]   digits;
  digit_t [NUM_DIMS-1:0]   digits_next;
  digit_t [NUM_DIMS-1:0]   dig;
  ext_t [NUM_DIMS-1:0]     ext;
  ext_t [NUM_DIMS-1:0]     dig_inc;
  dim_idx_t [NUM_DIMS-1:0] field;
  logic [NUM_DIMS-1:0]     seen;
  logic [DIM_W-1:0]        d;
  logic                    bad;
  logic                    last;
  logic                    carry;

  assign src.ready = !q_full;
  assign push      = src.valid && !q_full;

  always_comb begin
    d     = active_dims(cfg.dim_count);
    seen  = '0;
    bad   = 1'b0;
    last  = 1'b1;
    carry = 1'b1;
    for (int k = 0; k < NUM_DIMS; k++) begin
      field[k]   = cfg.order_map[2*k +: 2];
      ext[k]     = eff_extent(cfg.extent[k]);
      dig[k]     = (DIM_W'(k) < d) ? digits[k] : '0;
      dig_inc[k] = {1'b0, dig[k]} + EXT_W'(1);
      if (DIM_W'(k) < d) begin
        if ({1'b0, field[k]} >= d || seen[field[k]]) bad = 1'b1;
        seen[field[k]] = 1'b1;
        if (dig_inc[k] < ext[k]) last = 1'b0;
      end
    end
    for (int i = NUM_DIMS - 1; i >= 0; i--) begin
      digits_next[i] = '0;
      if (DIM_W'(i) < d) begin
        if (!carry) begin
          digits_next[i] = dig[i];
        end else if (dig_inc[i] < ext[i]) begin
          digits_next[i] = dig_inc[i][DIGIT_W-1:0];
          carry          = 1'b0;
        end
      end
    end
  end

  always_comb begin
    push_entry.vneg   = src.source_value[VALUE_W-1];
    push_entry.vmag   = src.source_value[VALUE_W-1] ? (~src.source_value + 32'sd1)
                                                    : src.source_value;
    push_entry.digits = dig;
    for (int k = 0; k < NUM_DIMS; k++) begin
      push_entry.perm[k] = bad ? IDX_W'(k) : field[k];
    end
    push_entry.steps  = d;
    push_entry.last   = last;
    push_entry.bad    = bad;
    push_entry.accum  = cfg.accumulate_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digits <= '0;
    end else if (push) begin
      digits <= digits_next;
    end
  end

endmodule

FILE: hw/rtl/tpsa_queue.sv
`timescale 1ns / 1ps

module tpsa_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tpsa_pkg::entry_t push_entry,
  input  logic             pop,
  output tpsa_pkg::entry_t head,
  output logic             full,
  output logic             empty
);
  import tpsa_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      if (push && !pop)      count <= count + CNT_W'(1);
      else if (pop && !push) count <= count - CNT_W'(1);
    end
  end

endmodule

FILE: hw/rtl/tpsa_back.sv
`timescale 1ns / 1ps

module tpsa_back (
  input  logic             clk,
  input  logic             rst,
  input  tpsa_pkg::cfg_t   cfg,
  input  tpsa_pkg::entry_t head,
  input  logic             q_empty,
  output logic             pop,
  tpsa_out_if.source       dst
);
  import tpsa_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t               state;
  entry_t               cur;
  logic [DIM_W-1:0]     k;
  logic [ADDR_W-1:0]    addr;
  logic [PROD_W-1:0]    pmag;
  logic                 neg;

  logic                 aneg;
  logic [SCALE_W-1:0]   amag;
  dim_idx_t             sel;
  logic [ADDR_W+EXT_W-1:0] prod;
  logic [ADDR_W-1:0]    addr_next;
  logic [PROD_W:0]      rnd;
  logic [MAG_W-1:0]     mag;
  logic [MAG_W-1:0]     limit;
  logic [MAG_W-1:0]     sat;
  logic [VALUE_W-1:0]   val;
  logic                 out_free;

  assign aneg = cfg.scale_factor[SCALE_W-1];
  assign amag = aneg ? (~cfg.scale_factor + 24'sd1) : cfg.scale_factor;
  assign pop  = (state == S_LOAD) && !q_empty;

  assign sel       = cur.perm[k[IDX_W-1:0]];
  assign prod      = (ADDR_W + EXT_W)'(addr) * (ADDR_W + EXT_W)'(eff_extent(cfg.extent[sel]));
  assign addr_next = prod[ADDR_W-1:0] + ADDR_W'(cur.digits[sel]);

  assign rnd   = (PROD_W + 1)'(pmag) + (PROD_W + 1)'(1 << (FRAC_W - 1));
  assign mag   = rnd[PROD_W:FRAC_W];
  assign limit = neg ? MAG_W'(64'h8000_0000) : MAG_W'(64'h7FFF_FFFF);
  assign sat   = (mag > limit) ? limit : mag;
  assign val   = neg ? (~sat[VALUE_W-1:0] + 32'd1) : sat[VALUE_W-1:0];

  assign out_free = !dst.valid || dst.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      dst.valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) dst.valid <= 1'b1;
      else if (dst.valid && dst.ready) dst.valid <= 1'b0;
      case (state)
        S_LOAD: begin
          if (!q_empty) state <= S_WALK;
        end
        S_WALK: begin
          if (k == cur.steps) state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_LOAD: begin
        cur  <= head;
        k    <= '0;
        addr <= '0;
        pmag <= PROD_W'(head.vmag) * PROD_W'(amag);
        neg  <= head.vneg ^ aneg;
      end
      S_WALK: begin
        if (k != cur.steps) begin
          addr <= addr_next;
          k    <= k + DIM_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          dst.dest_address    <= addr;
          dst.scaled_value    <= val;
          dst.add_to_existing <= cur.accum;
          dst.last_element    <= cur.last;
          dst.bad_order       <= cur.bad;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: hw/rtl/tensor_permute_scale_accumulate_top.sv
`timescale 1ns / 1ps
// Channel  Role    Handshake          Payload
// src      sink    valid / ready      source_value
// dst      source  valid / ready      dest_address, scaled_value, add_to_existing,
//                                     last_element, bad_order
// cfg      APB     psel / penable     paddr, pwdata, prdata (pready tied high)
//
// The back end takes each item through a load state with the magnitude multiply,
// one multiply-add per active dimension (dim_count capped at 4), a step that ends the walk,
// and a done state for rounding, saturation and the result register.
// The front end takes an item per cycle while the queue has room.
// rst (synchronous) clears the position counter, queue and result valid and
// restores the register defaults. A stalled result holds in its register and holds the back.

module tensor_permute_scale_accumulate_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  tpsa_in_if.sink                      src,
  tpsa_out_if.source                   dst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tpsa_pkg::PADDR_W-1:0] paddr,
  input  logic [tpsa_pkg::PDATA_W-1:0] pwdata,
  output logic [tpsa_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import tpsa_pkg::*;

  cfg_t   cfg;
  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   pop;
  logic   q_full;
  logic   q_empty;

  tpsa_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  tpsa_front u_front (
    .clk, .rst, .cfg, .src, .q_full, .push, .push_entry
  );

  tpsa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst, .push, .push_entry, .pop, .head, .full(q_full), .empty(q_empty)
  );

  tpsa_back u_back (
    .clk, .rst, .cfg, .head, .q_empty, .pop, .dst
  );

endmodule

FILE: hw/rtl/tpsa_checker.sv
`timescale 1ns / 1ps

module tpsa_checker (
  input logic        clk,
  input logic        rst,
  input logic        dst_valid,
  input logic        dst_ready,
  input logic [39:0] dst_dest_address,
  input logic [31:0] dst_scaled_value,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [4:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata
);

  localparam logic [4:0] ADDR_ORDER = 5'd20;
  localparam logic [4:0] ADDR_ACC   = 5'd28;

  a_reset_empty: assert property (@(posedge clk) rst |=> !dst_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_ready |=> dst_valid && $stable(dst_dest_address)
                                && $stable(dst_scaled_value))
    else $error("stalled result changed");

  a_acc_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr == ADDR_ACC) ##1
    (psel && !pwrite && paddr == ADDR_ACC) |-> prdata == {31'b0, $past(pwdata[0])})
    else $error("accumulate mode readback mismatch");

  a_order_reset: assert property (@(posedge clk)
    rst ##1 (psel && !pwrite && paddr == ADDR_ORDER) |-> prdata == 32'd228)
    else $error("order map reset value wrong");

endmodule

bind tensor_permute_scale_accumulate_top tpsa_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .dst_valid        (dst.valid),
  .dst_ready        (dst.ready),
  .dst_dest_address (dst.dest_address),
  .dst_scaled_value (dst.scaled_value),
  .psel             (psel),
  .penable          (penable),
  .pwrite           (pwrite),
  .paddr            (paddr),
  .pwdata           (pwdata),
  .prdata           (prdata)
);

FILE: verif/tb_tensor_permute_scale_accumulate_top.sv
`timescale 1ns / 1ps

module tb_tensor_permute_scale_accumulate_top;
  import tpsa_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_TARGET = 850;
  localparam int CALM_POINT  = 720;

  typedef struct packed {
    logic [39:0]        dest_address;
    logic signed [31:0] scaled_value;
    logic               add_to_existing;
    logic               last_element;
    logic               bad_order;
  } dest_write_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  tpsa_in_if  src_if ();
  tpsa_out_if dst_if ();

  tensor_permute_scale_accumulate_top dut (
    .clk     (clk),
    .rst     (rst),
    .src     (src_if),
    .dst     (dst_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register mirror and position counter
  logic [2:0]         cfg_dims;
  logic [10:0]        cfg_extent [4];
  logic [7:0]         cfg_order;
  logic signed [23:0] cfg_scale;
  logic               cfg_accumulate;
  int unsigned        digit_pos [4];

  logic [31:0] source_queue [$];
  dest_write_t pending_writes [$];
  dest_write_t want;
  int  error_count = 0;
  int  send_gap = 0;
  int  sink_gap = 0;
  int  stall_cycles = 0;
  bit  idle_on = 1'b1;

  always #1 clk = ~clk;

  function automatic int clamp_extent(input logic [10:0] e);
    if (e == 11'd0) return 1;
    if (e > 11'd1024) return 1024;
    return int'(e);
  endfunction

  function automatic logic [31:0] scale_q16(input logic signed [31:0] v);
    longint prod, mag, limit;
    bit neg;
    neg = (v < 0) != (cfg_scale < 0);
    prod = (v < 0 ? -longint'(v) : longint'(v)) *
           (cfg_scale < 0 ? -longint'(cfg_scale) : longint'(cfg_scale));
    mag = (prod + 64'sd32768) >>> 16;
    limit = neg ? 64'sd2147483648 : 64'sd2147483647;
    if (mag > limit) mag = limit;
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  function automatic dest_write_t permute_scale_element(input logic [31:0] raw);
    dest_write_t w;
    int active, field;
    int ext [4];
    int perm [4];
    logic [3:0] seen;
    logic [63:0] addr;
    bit bad, last;
    active = (cfg_dims > 3'd4) ? 4 : int'(cfg_dims);
    seen = '0;
    bad = 1'b0;
    last = 1'b1;
    addr = '0;
    for (int k = 0; k < 4; k++) begin
      ext[k] = clamp_extent(cfg_extent[k]);
      if (k >= active) digit_pos[k] = 0;
    end
    for (int k = 0; k < active; k++) begin
      field = int'((cfg_order >> (2 * k)) & 8'h3);
      if (field >= active || seen[field]) bad = 1'b1;
      seen[field] = 1'b1;
      perm[k] = field;
    end
    for (int k = 0; k < active; k++) begin
      if (bad) perm[k] = k;
      addr = addr * ext[perm[k]] + digit_pos[perm[k]];
      if (digit_pos[k] + 1 < ext[k]) last = 1'b0;
    end
    w.dest_address    = addr[39:0];
    w.scaled_value    = scale_q16(raw);
    w.add_to_existing = cfg_accumulate;
    w.last_element    = last;
    w.bad_order       = bad;
    // advance the multi-index, fastest digit first
    for (int k = active - 1; k >= 0; k--) begin
      if (digit_pos[k] + 1 < ext[k]) begin
        digit_pos[k]++;
        break;
      end
      digit_pos[k] = 0;
    end
    return w;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_DIM_COUNT:  cfg_dims = data[2:0];
      REG_EXTENT_0:   cfg_extent[0] = data[10:0];
      REG_EXTENT_1:   cfg_extent[1] = data[10:0];
      REG_EXTENT_2:   cfg_extent[2] = data[10:0];
      REG_EXTENT_3:   cfg_extent[3] = data[10:0];
      REG_ORDER_MAP:  cfg_order = data[7:0];
      REG_SCALE:      cfg_scale = data[23:0];
      REG_ACCUMULATE: cfg_accumulate = data[0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (source_queue.size() != 0 || src_if.valid || pending_writes.size() != 0);
  endtask

  // source driver
  always @(posedge clk) begin
    if (rst) begin
      src_if.valid        <= 1'b0;
      src_if.source_value <= '0;
      send_gap            <= 0;
    end else begin
      if (src_if.valid && src_if.ready)
        pending_writes.push_back(permute_scale_element(src_if.source_value));
      if (!src_if.valid || src_if.ready) begin
        if (send_gap != 0) begin
          send_gap     <= send_gap - 1;
          src_if.valid <= 1'b0;
        end else if (source_queue.size() != 0) begin
          src_if.valid        <= 1'b1;
          src_if.source_value <= source_queue.pop_front();
          if (idle_on && $urandom_range(0, 15) == 0) send_gap <= $urandom_range(1, 12);
        end else begin
          src_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      dst_if.ready <= 1'b0;
      sink_gap     <= 0;
    end else begin
      if (dst_if.valid && dst_if.ready) begin
        if (pending_writes.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, got address %0h value %0h",
                   $time, dst_if.dest_address, dst_if.scaled_value);
        end else begin
          want = pending_writes.pop_front();
          check_field("dest_address", want.dest_address, dst_if.dest_address);
          check_field("scaled_value", want.scaled_value, dst_if.scaled_value);
          check_field("add_to_existing", want.add_to_existing, dst_if.add_to_existing);
          check_field("last_element", want.last_element, dst_if.last_element);
          check_field("bad_order", want.bad_order, dst_if.bad_order);
        end
      end
      if (sink_gap != 0) begin
        sink_gap     <= sink_gap - 1;
        dst_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        sink_gap     <= $urandom_range(0, 11);
        dst_if.ready <= 1'b0;
      end else begin
        dst_if.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || psel || (src_if.valid && src_if.ready) || (dst_if.valid && dst_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int          queued_total;
    int          active;
    int          n;
    longint      volume;
    int          pool [4];
    int          j, tmp;
    logic [7:0]  order_word;
    logic [23:0] scale_word;
    logic [31:0] ext_word;
    logic [31:0] v;

    src_if.valid        = 1'b0;
    src_if.source_value = '0;
    dst_if.ready        = 1'b0;
    cfg_dims       = 3'd0;
    cfg_order      = 8'd228;
    cfg_scale      = 24'sd65536;
    cfg_accumulate = 1'b0;
    for (int k = 0; k < 4; k++) begin
      cfg_extent[k] = 11'd1;
      digit_pos[k]  = 0;
    end
    queued_total = 0;

    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // scalar tensor, unit scale
    source_queue.push_back(32'h0000_0000);
    source_queue.push_back(32'h0000_0001);
    source_queue.push_back(32'hFFFF_FFFF);
    source_queue.push_back(32'h7FFF_FFFF);
    source_queue.push_back(32'h8000_0000);
    source_queue.push_back(32'h0000_8000);
    wait_idle();

    // rounding ties away from zero
    write_reg(REG_SCALE, 32'h0000_0001);
    source_queue.push_back(32'h0000_8000);
    source_queue.push_back(32'hFFFF_8000);
    source_queue.push_back(32'h0000_7FFF);
    wait_idle();

    // saturation at both limits
    write_reg(REG_SCALE, 32'h0080_0000);
    source_queue.push_back(32'h8000_0000);
    source_queue.push_back(32'h7FFF_FFFF);
    source_queue.push_back(32'h0000_0100);
    wait_idle();
    write_reg(REG_SCALE, 32'h007F_FFFF);
    source_queue.push_back(32'h8000_0000);
    source_queue.push_back(32'hFFFF_FFFF);
    wait_idle();
    write_reg(REG_SCALE, 32'h0000_0000);
    source_queue.push_back(32'h1234_5678);
    wait_idle();

    // full 2x2x2 tensor with reversed order, accumulating
    write_reg(REG_DIM_COUNT, 32'd3);
    write_reg(REG_EXTENT_0, 32'd2);
    write_reg(REG_EXTENT_1, 32'd2);
    write_reg(REG_EXTENT_2, 32'd2);
    write_reg(REG_EXTENT_3, 32'd0);
    write_reg(REG_ORDER_MAP, 32'hC6);
    write_reg(REG_ACCUMULATE, 32'd1);
    write_reg(REG_SCALE, 32'h0001_0000);
    for (int i = 0; i < 8; i++) source_queue.push_back($urandom);
    wait_idle();

    // clamped dimension count and extents, order map not a permutation
    write_reg(REG_DIM_COUNT, 32'd7);
    write_reg(REG_EXTENT_0, 32'd0);
    write_reg(REG_EXTENT_1, 32'd2047);
    write_reg(REG_EXTENT_2, 32'd1);
    write_reg(REG_EXTENT_3, 32'd1);
    write_reg(REG_ORDER_MAP, 32'h00);
    source_queue.push_back($urandom);
    source_queue.push_back($urandom);

    while (queued_total < ITEM_TARGET) begin
      wait_idle();
      idle_on = (queued_total < CALM_POINT) && ($urandom_range(0, 3) != 0);

      if ($urandom_range(0, 3) != 0)
        write_reg(REG_DIM_COUNT, ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7)
                                                             : $urandom_range(0, 4));
      for (int k = 0; k < 4; k++) begin
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 11))
            0:       ext_word = 32'd0;
            1:       ext_word = 32'd1024;
            2:       ext_word = 32'd2047;
            3:       ext_word = $urandom_range(0, 2047);
            default: ext_word = $urandom_range(1, 4);
          endcase
          write_reg(reg_idx_t'(int'(REG_EXTENT_0) + k), ext_word);
        end
      end

      active = (cfg_dims > 3'd4) ? 4 : int'(cfg_dims);
      order_word = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) != 0) begin
        for (int k = 0; k < 4; k++) pool[k] = k;
        for (int k = active - 1; k > 0; k--) begin
          j = $urandom_range(0, k);
          tmp = pool[k];
          pool[k] = pool[j];
          pool[j] = tmp;
        end
        for (int k = 0; k < active; k++) order_word[2*k +: 2] = pool[k][1:0];
      end
      write_reg(REG_ORDER_MAP, order_word);

      if ($urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 4))
          0: scale_word = 24'($urandom_range(0, 24'hFF_FFFF));
          1: scale_word = 24'(24'h01_0000 + $urandom_range(0, 511) - 256);
          2: begin
            case ($urandom_range(0, 3))
              0:       scale_word = 24'h80_0000;
              1:       scale_word = 24'h7F_FFFF;
              2:       scale_word = 24'h00_0000;
              default: scale_word = 24'hFF_0000;
            endcase
          end
          3: begin
            scale_word = 24'($urandom_range(0, 255));
            if ($urandom_range(0, 1) == 1) scale_word = -scale_word;
          end
          default: scale_word = 24'h01_0000;
        endcase
        write_reg(REG_SCALE, {8'd0, scale_word});
      end
      if ($urandom_range(0, 1) == 1) write_reg(REG_ACCUMULATE, $urandom_range(0, 1));

      volume = 1;
      for (int k = 0; k < active; k++) volume = volume * clamp_extent(cfg_extent[k]);
      if (volume <= 64) begin
        n = int'(volume) * $urandom_range(1, 2);
        if ($urandom_range(0, 3) == 0) n += $urandom_range(1, 3);
      end else begin
        n = $urandom_range(16, 64);
      end

      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 7))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2, 3: begin
            v = $urandom_range(0, 32'h3_FFFF);
            if ($urandom_range(0, 1) == 1) v = -v;
          end
          default: v = $urandom;
        endcase
        source_queue.push_back(v);
      end
      queued_total += n;
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0 && pending_writes.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
